FILE: rtl/ecm_pkg.sv
`timescale 1ns / 1ps
package ecm_pkg;

  localparam int CFG_AW = 5;

  // register map, one word per register
  typedef enum logic [2:0] {
    REG_SENS  = 3'd0,
    REG_SPEED = 3'd1,
    REG_UP_X  = 3'd2,
    REG_UP_Y  = 3'd3,
    REG_UP_Z  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] sens;
    logic [15:0] speed;
    logic [15:0] up_x;
    logic [15:0] up_y;
    logic [15:0] up_z;
  } cfg_t;

  localparam logic [15:0] SENS_RESET  = 16'd6554;
  localparam logic [15:0] SPEED_RESET = 16'd128;
  localparam logic [15:0] UP_Y_RESET  = 16'd16384;

  // angles in Q16 degrees
  localparam logic signed [34:0] FULL_TURN   = 35'sd23592960;
  localparam logic signed [34:0] HALF_TURN   = 35'sd11796480;
  localparam logic signed [34:0] PITCH_LIMIT = 35'sd5832704;
  localparam logic signed [25:0] HALF_TURN_Z = 26'sd11796480;
  localparam logic signed [25:0] QUARTER_Z   = 26'sd5898240;
  localparam logic signed [25:0] YAW_RESET   = -26'sd5898240;

  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam int CORDIC_STEPS = 16;
  localparam logic signed [25:0] ATAN_Q16 [CORDIC_STEPS] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379, 26'sd117304, 26'sd58666, 26'sd29335,
    26'sd14668, 26'sd7334, 26'sd3667, 26'sd1833,
    26'sd917, 26'sd458, 26'sd229, 26'sd115
  };

  localparam logic signed [15:0] UNIT_Q14   = 16'sd16384;
  localparam logic [31:0]        UNIT_Q14_U = 32'd16384;
  localparam logic signed [65:0] ROUND_Q30  = 66'sd536870912;
  localparam logic signed [65:0] ROUND_Q14  = 66'sd8192;
  localparam logic [31:0]        NS_PER_S   = 32'd1000000000;
  localparam logic [63:0]        HALF_NS    = 64'd500000000;
  localparam logic signed [32:0] SPEED_SCALE = 33'sd100;
  localparam logic signed [34:0] POS_MAX    = 35'sd2147483647;
  localparam logic signed [34:0] POS_MIN    = -35'sd2147483648;

  // cross product operand order: c0 = a1 b2 - a2 b1, c1 = a2 b0 - a0 b2, c2 = a0 b1 - a1 b0
  localparam logic [1:0] XA_IDX [6] = '{2'd1, 2'd2, 2'd2, 2'd0, 2'd0, 2'd1};
  localparam logic [1:0] XB_IDX [6] = '{2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0};

  typedef enum logic [1:0] {
    PH_FRONT,
    PH_RIGHT,
    PH_UP
  } ph_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_M_MULX,
    ST_M_MULY,
    ST_M_PITCH,
    ST_M_MOD,
    ST_M_WRAP,
    ST_C_YAW,
    ST_C_YAW_W,
    ST_C_PIT,
    ST_C_PIT_W,
    ST_F0,
    ST_F2,
    ST_F3,
    ST_N_SQ,
    ST_N_ACC,
    ST_N_SQRT,
    ST_N_SQRT_W,
    ST_N_DIV,
    ST_N_DIV_W,
    ST_X_MUL,
    ST_X_ACC,
    ST_T_MUL0,
    ST_T_MUL1,
    ST_T_DIV,
    ST_T_DIV_W,
    ST_T_KEY,
    ST_T_MUL,
    ST_T_ADD,
    ST_DONE
  } st_t;

endpackage

FILE: rtl/ecm_chan_if.sv
`timescale 1ns / 1ps
interface ecm_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [15:0] mouse_dx;
  logic signed [15:0] mouse_dy;
  logic [29:0]        tick_nanoseconds;
  logic               key_forward;
  logic               key_back;
  logic               key_left;
  logic               key_right;

  modport source (output valid, command, mouse_dx, mouse_dy, tick_nanoseconds,
                  key_forward, key_back, key_left, key_right, input ready);
  modport sink (input valid, command, mouse_dx, mouse_dy, tick_nanoseconds,
                key_forward, key_back, key_left, key_right, output ready);
endinterface

interface ecm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] front_x;
  logic signed [15:0] front_y;
  logic signed [15:0] front_z;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;
  logic signed [15:0] right_z;
  logic signed [15:0] up_x;
  logic signed [15:0] up_y;
  logic signed [15:0] up_z;

  modport source (output valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                  right_x, right_y, right_z, up_x, up_y, up_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                right_x, right_y, right_z, up_x, up_y, up_z, output ready);
endinterface

FILE: rtl/ecm_cfg.sv
`timescale 1ns / 1ps
module ecm_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ecm_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output ecm_pkg::cfg_t               cfg
);
  import ecm_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;

  assign idx = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sens  <= SENS_RESET;
      cfg_r.speed <= SPEED_RESET;
      cfg_r.up_x  <= '0;
      cfg_r.up_y  <= UP_Y_RESET;
      cfg_r.up_z  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_SENS:  cfg_r.sens  <= pwdata[15:0];
        REG_SPEED: cfg_r.speed <= pwdata[15:0];
        REG_UP_X:  cfg_r.up_x  <= pwdata[15:0];
        REG_UP_Y:  cfg_r.up_y  <= pwdata[15:0];
        REG_UP_Z:  cfg_r.up_z  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SENS:  prdata = {16'b0, cfg_r.sens};
      REG_SPEED: prdata = {16'b0, cfg_r.speed};
      REG_UP_X:  prdata = {{16{cfg_r.up_x[15]}}, cfg_r.up_x};
      REG_UP_Y:  prdata = {{16{cfg_r.up_y[15]}}, cfg_r.up_y};
      REG_UP_Z:  prdata = {{16{cfg_r.up_z[15]}}, cfg_r.up_z};
      default:   prdata = '0;
    endcase
  end

endmodule

FILE: rtl/ecm_cordic.sv
`timescale 1ns / 1ps
module ecm_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [25:0] angle,
  output logic               done,
  output logic signed [32:0] cos_q30,
  output logic signed [32:0] sin_q30
);
  import ecm_pkg::*;

  logic signed [32:0] x_r, y_r;
  logic signed [25:0] z_r;
  logic               neg_r;
  logic               busy_r, done_r;
  logic [3:0]         cnt_r;
  logic signed [25:0] z_fold;
  logic               neg_fold;
  logic signed [32:0] xs, ys;

  // fold into [-90, 90], negate both results afterwards
  always_comb begin
    z_fold   = angle;
    neg_fold = 1'b0;
    if (angle > QUARTER_Z) begin
      z_fold   = angle - HALF_TURN_Z;
      neg_fold = 1'b1;
    end else if (angle < -QUARTER_Z) begin
      z_fold   = angle + HALF_TURN_Z;
      neg_fold = 1'b1;
    end
  end

  assign xs = x_r >>> cnt_r;
  assign ys = y_r >>> cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= CORDIC_GAIN;
      y_r   <= '0;
      z_r   <= z_fold;
      neg_r <= neg_fold;
    end else if (busy_r) begin
      if (!z_r[25]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - ATAN_Q16[cnt_r];
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + ATAN_Q16[cnt_r];
      end
    end
  end

  assign done    = done_r;
  assign cos_q30 = neg_r ? -x_r : x_r;
  assign sin_q30 = neg_r ? -y_r : y_r;

endmodule

FILE: rtl/ecm_isqrt.sv
`timescale 1ns / 1ps
module ecm_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  logic [63:0] x_r, r_r, bit_r;
  logic        busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [63:0] trial;

  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (&cnt_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // one result bit per cycle, two radicand bits consumed
  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= radicand;
      r_r   <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (x_r >= trial) begin
        x_r <= x_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[31:0];

endmodule

FILE: rtl/ecm_div.sv
`timescale 1ns / 1ps
module ecm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  // quotient must fit 32 bits: dividend below divisor * 2^32
  logic [32:0] rem_r;
  logic [31:0] low_r, q_r, d_r;
  logic        busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem_r[31:0], low_r[31]};
  assign fits  = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (&cnt_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend[63:32]};
      low_r <= dividend[31:0];
      d_r   <= divisor;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? trial - {1'b0, d_r} : trial;
      low_r <= {low_r[30:0], 1'b0};
      q_r   <= {q_r[30:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: rtl/euler_camera_orientation_and_move.sv
`timescale 1ns / 1ps
// First-person camera unit working one item at a time. A mouse item turns yaw
// and pitch, then rebuilds front, right and up, using two 16-step CORDIC runs
// and, for each of the three vectors, one 32-step square root and three 32-step
// divisions, all on shared units around one 33x33 multiplier (a zero-length
// vector skips its divisions). A tick item runs one 32-step division for the
// velocity, then checks each key in turn and steps the position along all three
// axes for each held key. in_chan.ready is high only between items; the result
// sits in an output register, so the next item can be taken while it waits.
// Configuration is an APB port with pready tied high; a new world up is read
// directly by the cross product for the right vector.
module euler_camera_orientation_and_move (
  input  logic                       clk,
  input  logic                       rst_n,
  ecm_in_if.sink                     in_chan,
  ecm_out_if.source                  out_chan,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ecm_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import ecm_pkg::*;

  cfg_t cfg;

  st_t  state_r, state_nxt;
  ph_t  phase_r;

  logic signed [15:0] dx_r, dy_r;
  logic [29:0]        ns_r;
  logic [3:0]         keys_r;

  logic signed [25:0] yaw_r;
  logic signed [23:0] pitch_r;
  logic signed [31:0] pos_r   [3];
  logic signed [15:0] front_r [3];
  logic signed [15:0] right_r [3];
  logic signed [15:0] up_r    [3];
  logic signed [15:0] wup     [3];

  logic signed [34:0] acc_r;
  logic [2:0]         mod_k_r;
  logic [1:0]         idx_r;
  logic [2:0]         xj_r;
  logic [1:0]         key_r;
  logic [63:0]        ss_r;
  logic [31:0]        len_r, vel_r;
  logic signed [32:0] cy_r, sy_r, cp_r, sp_r;
  logic signed [32:0] v_r [3];

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;

  logic               cor_start, cor_done;
  logic signed [25:0] cor_angle;
  logic signed [32:0] cor_cos, cor_sin;
  logic               sq_start, sq_done;
  logic [31:0]        sq_root;
  logic               div_start, div_done;
  logic [63:0]        div_dvd;
  logic [31:0]        div_dvs, div_q;

  logic               out_valid_r;
  logic signed [31:0] opos_r [3];
  logic signed [15:0] ofr_r  [3];
  logic signed [15:0] ori_r  [3];
  logic signed [15:0] oup_r  [3];

  logic [32:0]        vmag;
  logic signed [15:0] xa, xb, tdir;
  logic signed [34:0] fk, pit_new, pit_clamp, wrap_t, wrap_w;
  logic signed [65:0] f_round, d_round;
  logic signed [33:0] step_d;
  logic signed [34:0] pos_sum;
  logic [14:0]        qc;
  logic signed [15:0] nres;
  logic               comp_done;
  logic               out_load;

  ecm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );
  assign cfg_pready = 1'b1;

  ecm_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_start),
    .angle   (cor_angle),
    .done    (cor_done),
    .cos_q30 (cor_cos),
    .sin_q30 (cor_sin)
  );

  ecm_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (ss_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  ecm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  assign wup[0] = $signed(cfg.up_x);
  assign wup[1] = $signed(cfg.up_y);
  assign wup[2] = $signed(cfg.up_z);

  // datapath helpers
  always_comb begin
    vmag = v_r[idx_r][32] ? 33'(-v_r[idx_r]) : 33'(v_r[idx_r]);
    if (phase_r == PH_RIGHT) begin
      xa = front_r[XA_IDX[xj_r]];
      xb = wup[XB_IDX[xj_r]];
    end else begin
      xa = right_r[XA_IDX[xj_r]];
      xb = front_r[XB_IDX[xj_r]];
    end
    tdir = key_r[1] ? right_r[idx_r] : front_r[idx_r];

    fk = FULL_TURN << mod_k_r;

    pit_new = $signed({{11{pitch_r[23]}}, pitch_r}) - prod_r[34:0];
    if (pit_new > PITCH_LIMIT)       pit_clamp = PITCH_LIMIT;
    else if (pit_new < -PITCH_LIMIT) pit_clamp = -PITCH_LIMIT;
    else                             pit_clamp = pit_new;

    wrap_t = acc_r[34] ? acc_r + FULL_TURN : acc_r;
    wrap_w = (wrap_t >= HALF_TURN) ? wrap_t - FULL_TURN : wrap_t;

    f_round = prod_r + ROUND_Q30;
    d_round = prod_r + ROUND_Q14;
    step_d  = d_round[47:14];
    // back and left subtract
    if (key_r[0] ^ key_r[1])
      pos_sum = $signed({{3{pos_r[idx_r][31]}}, pos_r[idx_r]}) - step_d;
    else
      pos_sum = $signed({{3{pos_r[idx_r][31]}}, pos_r[idx_r]}) + step_d;

    qc = (div_q > UNIT_Q14_U) ? 15'(UNIT_Q14) : div_q[14:0];
    // zero-length vector normalizes to zero
    if (len_r == '0)
      nres = '0;
    else
      nres = v_r[idx_r][32] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});

    comp_done = ((state_r == ST_N_DIV) && (len_r == '0)) ||
                ((state_r == ST_N_DIV_W) && div_done);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_M_MULX: begin
        mul_a = {{17{dx_r[15]}}, dx_r};
        mul_b = {17'b0, cfg.sens};
      end
      ST_M_MULY: begin
        mul_a = {{17{dy_r[15]}}, dy_r};
        mul_b = {17'b0, cfg.sens};
      end
      ST_F0: begin
        mul_a = cy_r;
        mul_b = cp_r;
      end
      ST_F2: begin
        mul_a = sy_r;
        mul_b = cp_r;
      end
      ST_N_SQ: begin
        mul_a = {1'b0, vmag[31:0]};
        mul_b = {1'b0, vmag[31:0]};
      end
      ST_X_MUL: begin
        mul_a = {{17{xa[15]}}, xa};
        mul_b = {{17{xb[15]}}, xb};
      end
      ST_T_MUL0: begin
        mul_a = {17'b0, cfg.speed};
        mul_b = SPEED_SCALE;
      end
      ST_T_MUL1: begin
        mul_a = {10'b0, prod_r[22:0]};
        mul_b = {3'b0, ns_r};
      end
      ST_T_MUL: begin
        mul_a = {1'b0, vel_r};
        mul_b = {{17{tdir[15]}}, tdir};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    cor_start = 1'b0;
    cor_angle = $signed({{2{pitch_r[23]}}, pitch_r});
    sq_start  = 1'b0;
    div_start = 1'b0;
    div_dvd   = ({32'b0, vmag[31:0]} << 14) + {33'b0, len_r[31:1]};
    div_dvs   = len_r;
    unique case (state_r)
      ST_IDLE:    if (in_chan.valid) state_nxt = in_chan.command ? ST_T_MUL0 : ST_M_MULX;
      ST_M_MULX:  state_nxt = ST_M_MULY;
      ST_M_MULY:  state_nxt = ST_M_PITCH;
      ST_M_PITCH: state_nxt = ST_M_MOD;
      ST_M_MOD:   if (mod_k_r == '0) state_nxt = ST_M_WRAP;
      ST_M_WRAP:  state_nxt = ST_C_YAW;
      ST_C_YAW: begin
        cor_start = 1'b1;
        cor_angle = yaw_r;
        state_nxt = ST_C_YAW_W;
      end
      ST_C_YAW_W: if (cor_done) state_nxt = ST_C_PIT;
      ST_C_PIT: begin
        cor_start = 1'b1;
        state_nxt = ST_C_PIT_W;
      end
      ST_C_PIT_W: if (cor_done) state_nxt = ST_F0;
      ST_F0:      state_nxt = ST_F2;
      ST_F2:      state_nxt = ST_F3;
      ST_F3:      state_nxt = ST_N_SQ;
      ST_N_SQ:    state_nxt = ST_N_ACC;
      ST_N_ACC:   state_nxt = (idx_r == 2'd2) ? ST_N_SQRT : ST_N_SQ;
      ST_N_SQRT: begin
        sq_start  = 1'b1;
        state_nxt = ST_N_SQRT_W;
      end
      ST_N_SQRT_W: if (sq_done) state_nxt = ST_N_DIV;
      ST_N_DIV, ST_N_DIV_W: begin
        if (state_r == ST_N_DIV && len_r != '0) begin
          div_start = 1'b1;
          state_nxt = ST_N_DIV_W;
        end else if (comp_done) begin
          if (idx_r != 2'd2)          state_nxt = ST_N_DIV;
          else if (phase_r == PH_UP)  state_nxt = ST_DONE;
          else                        state_nxt = ST_X_MUL;
        end
      end
      ST_X_MUL:   state_nxt = ST_X_ACC;
      ST_X_ACC:   state_nxt = (xj_r == 3'd5) ? ST_N_SQ : ST_X_MUL;
      ST_T_MUL0:  state_nxt = ST_T_MUL1;
      ST_T_MUL1:  state_nxt = ST_T_DIV;
      ST_T_DIV: begin
        div_start = 1'b1;
        div_dvd   = {3'b0, prod_r[52:0], 8'b0} + HALF_NS;
        div_dvs   = NS_PER_S;
        state_nxt = ST_T_DIV_W;
      end
      ST_T_DIV_W: if (div_done) state_nxt = ST_T_KEY;
      ST_T_KEY: begin
        if (keys_r[key_r])       state_nxt = ST_T_MUL;
        else if (key_r == 2'd3)  state_nxt = ST_DONE;
      end
      ST_T_MUL:   state_nxt = ST_T_ADD;
      ST_T_ADD: begin
        if (idx_r != 2'd2)      state_nxt = ST_T_MUL;
        else if (key_r == 2'd3) state_nxt = ST_DONE;
        else                    state_nxt = ST_T_KEY;
      end
      ST_DONE:    if (out_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // camera state, reset to the initial pose
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_r      <= YAW_RESET;
      pitch_r    <= '0;
      pos_r[0]   <= '0;
      pos_r[1]   <= '0;
      pos_r[2]   <= '0;
      front_r[0] <= '0;
      front_r[1] <= '0;
      front_r[2] <= -UNIT_Q14;
      right_r[0] <= UNIT_Q14;
      right_r[1] <= '0;
      right_r[2] <= '0;
      up_r[0]    <= '0;
      up_r[1]    <= UNIT_Q14;
      up_r[2]    <= '0;
    end else begin
      if (state_r == ST_M_PITCH) pitch_r <= pit_clamp[23:0];
      if (state_r == ST_M_WRAP)  yaw_r   <= wrap_w[25:0];
      if (comp_done) begin
        case (phase_r)
          PH_FRONT: front_r[idx_r] <= nres;
          PH_RIGHT: right_r[idx_r] <= nres;
          default:  up_r[idx_r]    <= nres;
        endcase
      end
      if (state_r == ST_T_ADD) begin
        if (pos_sum > POS_MAX)      pos_r[idx_r] <= POS_MAX[31:0];
        else if (pos_sum < POS_MIN) pos_r[idx_r] <= POS_MIN[31:0];
        else                        pos_r[idx_r] <= pos_sum[31:0];
      end
    end
  end

  // sequencing counters and phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FRONT;
      idx_r   <= '0;
      xj_r    <= '0;
      key_r   <= '0;
      mod_k_r <= '0;
    end else begin
      case (state_r)
        ST_M_PITCH: mod_k_r <= 3'd7;
        ST_M_MOD:   mod_k_r <= mod_k_r - 3'd1;
        ST_F3: begin
          phase_r <= PH_FRONT;
          idx_r   <= '0;
        end
        ST_N_ACC:    idx_r <= (idx_r == 2'd2) ? 2'd0 : idx_r + 2'd1;
        ST_N_DIV, ST_N_DIV_W: begin
          if (comp_done) begin
            if (idx_r != 2'd2) begin
              idx_r <= idx_r + 2'd1;
            end else begin
              idx_r <= '0;
              xj_r  <= '0;
              phase_r <= (phase_r == PH_FRONT) ? PH_RIGHT : PH_UP;
            end
          end
        end
        ST_X_ACC:   xj_r <= (xj_r == 3'd5) ? 3'd0 : xj_r + 3'd1;
        ST_T_DIV_W: key_r <= '0;
        ST_T_KEY: begin
          if (keys_r[key_r]) idx_r <= '0;
          else               key_r <= key_r + 2'd1;
        end
        ST_T_ADD: begin
          if (idx_r != 2'd2) begin
            idx_r <= idx_r + 2'd1;
          end else begin
            idx_r <= '0;
            key_r <= key_r + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_chan.valid) begin
      dx_r   <= in_chan.mouse_dx;
      dy_r   <= in_chan.mouse_dy;
      ns_r   <= in_chan.tick_nanoseconds;
      keys_r <= {in_chan.key_right, in_chan.key_left, in_chan.key_back, in_chan.key_forward};
    end
    case (state_r)
      ST_M_MULY: acc_r <= $signed({{9{yaw_r[25]}}, yaw_r}) + prod_r[34:0];
      ST_M_MOD: begin
        // reduce modulo the full turn, one power-of-two multiple a cycle
        if (acc_r >= fk)   acc_r <= acc_r - fk;
        else if (acc_r[34]) acc_r <= acc_r + fk;
      end
      ST_C_YAW_W: if (cor_done) begin
        cy_r <= cor_cos;
        sy_r <= cor_sin;
      end
      ST_C_PIT_W: if (cor_done) begin
        cp_r <= cor_cos;
        sp_r <= cor_sin;
      end
      ST_F2:      v_r[0] <= f_round[62:30];
      ST_F3: begin
        v_r[2] <= f_round[62:30];
        v_r[1] <= sp_r;
      end
      ST_N_ACC:   ss_r <= ((idx_r == 2'd0) ? 64'd0 : ss_r) + prod_r[63:0];
      ST_N_SQRT_W: if (sq_done) len_r <= sq_root;
      ST_X_ACC: begin
        if (!xj_r[0]) v_r[xj_r[2:1]] <= prod_r[32:0];
        else          v_r[xj_r[2:1]] <= v_r[xj_r[2:1]] - prod_r[32:0];
      end
      ST_T_DIV_W: if (div_done) vel_r <= div_q;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < 3; i++) begin
        opos_r[i] <= pos_r[i];
        ofr_r[i]  <= front_r[i];
        ori_r[i]  <= right_r[i];
        oup_r[i]  <= up_r[i];
      end
    end
  end

  assign in_chan.ready    = (state_r == ST_IDLE);
  assign out_chan.valid   = out_valid_r;
  assign out_chan.pos_x   = opos_r[0];
  assign out_chan.pos_y   = opos_r[1];
  assign out_chan.pos_z   = opos_r[2];
  assign out_chan.front_x = ofr_r[0];
  assign out_chan.front_y = ofr_r[1];
  assign out_chan.front_z = ofr_r[2];
  assign out_chan.right_x = ori_r[0];
  assign out_chan.right_y = ori_r[1];
  assign out_chan.right_z = ori_r[2];
  assign out_chan.up_x    = oup_r[0];
  assign out_chan.up_y    = oup_r[1];
  assign out_chan.up_z    = oup_r[2];

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import ecm_pkg::*;

  typedef struct {
    bit               command;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [29:0]      ns;
    bit               fwd;
    bit               back;
    bit               left;
    bit               right;
  } cam_item_t;

  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] fx, fy, fz, rx, ry, rz, ux, uy, uz;
  } cam_view_t;

  typedef longint vec3_t [3];

  localparam longint TURN_360 = 360 * 65536;
  localparam longint TURN_180 = 180 * 65536;
  localparam longint TURN_90  = 90 * 65536;
  localparam longint LIMIT_89 = 89 * 65536;
  localparam longint ATAN_TBL [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                       58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                       229, 115};

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  ecm_in_if  in_if ();
  ecm_out_if out_if ();

  euler_camera_orientation_and_move i_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_if), .out_chan(out_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // camera model state
  longint unsigned m_sens, m_speed;
  vec3_t m_world_up, m_pos, m_front, m_right, m_up;
  longint m_yaw, m_pitch;

  cam_item_t pending_items[$];
  cam_view_t expected_views[$];
  cam_item_t cur_item;
  int mismatches = 0;
  int in_gap = 0, out_stall = 0;
  bit in_burst = 0, out_burst = 0;
  logic drv_busy;

  initial begin
    in_if.valid = 0; in_if.command = 0; in_if.mouse_dx = 0; in_if.mouse_dy = 0;
    in_if.tick_nanoseconds = 0; in_if.key_forward = 0; in_if.key_back = 0;
    in_if.key_left = 0; in_if.key_right = 0;
    out_if.ready = 0;
  end

  function automatic void cordic_deg(input longint a, output longint c, output longint s);
    longint x, y, z, nx;
    bit neg;
    x = 652032874; y = 0; z = a; neg = 0;
    if (z > TURN_90) begin
      z -= TURN_180; neg = 1;
    end else if (z < -TURN_90) begin
      z += TURN_180; neg = 1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= ATAN_TBL[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += ATAN_TBL[i];
      end
      x = nx;
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void unit_vec(input vec3_t v, output vec3_t o);
    longint unsigned ss, len, q, m;
    ss = 0;
    for (int i = 0; i < 3; i++) begin
      m = (v[i] < 0) ? -v[i] : v[i];
      ss += m * m;
    end
    len = int_sqrt(ss);
    for (int i = 0; i < 3; i++) begin
      m = (v[i] < 0) ? -v[i] : v[i];
      if (len == 0) begin
        o[i] = 0;
      end else begin
        q = (m * 16384 + len / 2) / len;
        if (q > 16384) q = 16384;
        o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
    end
  endfunction

  function automatic void cross_prod(input vec3_t a, input vec3_t b, output vec3_t c);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic void step_along(input vec3_t dir, input longint vel, input bit neg);
    longint d, p;
    for (int i = 0; i < 3; i++) begin
      d = (vel * dir[i] + 8192) >>> 14;
      p = neg ? m_pos[i] - d : m_pos[i] + d;
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      m_pos[i] = p;
    end
  endfunction

  function automatic cam_view_t next_view(input cam_item_t it);
    longint y, p, cy, sy, cp, sp, vel;
    longint unsigned num;
    vec3_t f, t;
    cam_view_t v;
    if (!it.command) begin
      y = m_yaw + longint'(it.dx) * longint'(m_sens);
      p = m_pitch - longint'(it.dy) * longint'(m_sens);
      y = y % TURN_360;
      if (y < 0) y += TURN_360;
      if (y >= TURN_180) y -= TURN_360;
      if (p > LIMIT_89) p = LIMIT_89;
      else if (p < -LIMIT_89) p = -LIMIT_89;
      m_yaw = y; m_pitch = p;
      cordic_deg(m_yaw, cy, sy);
      cordic_deg(m_pitch, cp, sp);
      f[0] = (cy * cp + (64'sd1 << 29)) >>> 30;
      f[1] = sp;
      f[2] = (sy * cp + (64'sd1 << 29)) >>> 30;
      unit_vec(f, m_front);
      cross_prod(m_front, m_world_up, t);
      unit_vec(t, m_right);
      cross_prod(m_right, m_front, t);
      unit_vec(t, m_up);
    end else begin
      num = m_speed * 100 * longint'(it.ns) * 256;
      vel = longint'((num + 64'd500000000) / 64'd1000000000);
      if (it.fwd) step_along(m_front, vel, 0);
      if (it.back) step_along(m_front, vel, 1);
      if (it.left) step_along(m_right, vel, 1);
      if (it.right) step_along(m_right, vel, 0);
    end
    v.px = m_pos[0]; v.py = m_pos[1]; v.pz = m_pos[2];
    v.fx = m_front[0]; v.fy = m_front[1]; v.fz = m_front[2];
    v.rx = m_right[0]; v.ry = m_right[1]; v.rz = m_right[2];
    v.ux = m_up[0]; v.uy = m_up[1]; v.uz = m_up[2];
    return v;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst_n) begin
      drv_busy = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        expected_views.push_back(next_view(cur_item));
        drv_busy = 0;
      end
      if (!drv_busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          in_if.command <= cur_item.command;
          in_if.mouse_dx <= cur_item.dx;
          in_if.mouse_dy <= cur_item.dy;
          in_if.tick_nanoseconds <= cur_item.ns;
          in_if.key_forward <= cur_item.fwd;
          in_if.key_back <= cur_item.back;
          in_if.key_left <= cur_item.left;
          in_if.key_right <= cur_item.right;
          drv_busy = 1;
          if ($urandom_range(0, 40) == 0) in_burst = ~in_burst;
          in_gap = in_burst ? 0 : $urandom_range(0, 3);
        end
      end
      in_if.valid <= drv_busy;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_views.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
        end else begin
          cam_view_t exp_v, got_v;
          exp_v = expected_views.pop_front();
          got_v = {out_if.pos_x, out_if.pos_y, out_if.pos_z, out_if.front_x,
                   out_if.front_y, out_if.front_z, out_if.right_x, out_if.right_y,
                   out_if.right_z, out_if.up_x, out_if.up_y, out_if.up_z};
          if (got_v !== exp_v) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at %0t: expected %h actual %h", $realtime, exp_v, got_v);
          end
        end
        if ($urandom_range(0, 40) == 0) out_burst = ~out_burst;
        out_stall = out_burst ? 0 : $urandom_range(0, 3);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_if.ready <= 0;
      end else begin
        out_if.ready <= 1;
      end
    end
  end

  task automatic reg_write(input int idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= CFG_AW'(idx * 4); cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    case (idx)
      REG_SENS:  m_sens = val[15:0];
      REG_SPEED: m_speed = val[15:0];
      REG_UP_X:  m_world_up[0] = longint'($signed(val[15:0]));
      REG_UP_Y:  m_world_up[1] = longint'($signed(val[15:0]));
      REG_UP_Z:  m_world_up[2] = longint'($signed(val[15:0]));
      default: ;
    endcase
  endtask

  task automatic add_mouse(input int dx, input int dy);
    cam_item_t it;
    it.command = 0; it.dx = dx; it.dy = dy;
    it.ns = $urandom; it.fwd = $urandom; it.back = $urandom;
    it.left = $urandom; it.right = $urandom;
    pending_items.push_back(it);
  endtask

  task automatic add_tick(input int unsigned ns, input bit [3:0] keys);
    cam_item_t it;
    it.command = 1; it.dx = $urandom; it.dy = $urandom; it.ns = ns;
    {it.fwd, it.back, it.left, it.right} = keys;
    pending_items.push_back(it);
  endtask

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 40) begin
        if ($urandom_range(0, 9) < 8)
          add_mouse($signed($urandom_range(0, 127)) - 64, $signed($urandom_range(0, 63)) - 32);
        else
          add_mouse($signed($urandom_range(0, 65535)) - 32768,
                    $signed($urandom_range(0, 65535)) - 32768);
      end else begin
        add_tick($urandom_range(0, 1000000000), $urandom_range(0, 15));
      end
    end
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_if.valid || expected_views.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    m_sens = 6554; m_speed = 128;
    m_world_up = '{0, 16384, 0};
    m_yaw = -TURN_90; m_pitch = 0;
    m_pos = '{0, 0, 0}; m_front = '{0, 0, -16384};
    m_right = '{16384, 0, 0}; m_up = '{0, 16384, 0};
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // reset defaults, directed corners
    add_tick(0, 4'b1111);
    add_tick(1000000000, 4'b1000);
    add_tick(1000000000, 4'b0100);
    add_tick(999999999, 4'b0010);
    add_tick(500000000, 4'b0001);
    add_mouse(0, 0);
    add_mouse(32767, 0);
    add_mouse(-32768, 0);
    add_mouse(0, 32767);
    add_mouse(0, -32768);
    add_mouse(-32768, 32767);
    add_tick(1000000000, 4'b1111);
    add_tick(123456789, 4'b1001);
    drain();

    // extremes: fast speed and sensitivity, saturating position
    reg_write(REG_SENS, 32'hFFFF);
    reg_write(REG_SPEED, 32'hFFFF);
    reg_write(REG_UP_X, 32'h0000_4000);
    reg_write(REG_UP_Y, 32'h0000_0000);
    reg_write(REG_UP_Z, 32'hFFFF_C000);
    reg_write(7, 32'h1234_5678); // unmapped, ignored
    add_mouse(1, -1);
    repeat (6) add_tick(1000000000, 4'b1000);
    repeat (6) add_tick(1000000000, 4'b0100);
    add_random(120);
    drain();

    // zero world up gives a degenerate basis
    reg_write(REG_SENS, 0);
    reg_write(REG_SPEED, 0);
    reg_write(REG_UP_X, 0);
    reg_write(REG_UP_Z, 0);
    add_mouse(100, 100);
    add_tick(1000000000, 4'b1111);
    drain();
    reg_write(REG_SENS, 6554);
    reg_write(REG_SPEED, 300);
    add_random(100);
    drain();

    // world up along z, view angles held by zero sensitivity
    reg_write(REG_UP_Z, 32'h0000_4000);
    reg_write(REG_UP_Y, 0);
    reg_write(REG_SENS, 0);
    add_mouse(0, 0);
    add_tick(1000000000, 4'b0011);
    drain();

    // random settings
    repeat (3) begin
      reg_write(REG_SENS, $urandom_range(0, 65535));
      reg_write(REG_SPEED, $urandom_range(0, 65535));
      reg_write(REG_UP_X, $signed($urandom_range(0, 32768)) - 16384);
      reg_write(REG_UP_Y, $signed($urandom_range(0, 32768)) - 16384);
      reg_write(REG_UP_Z, $signed($urandom_range(0, 32768)) - 16384);
      add_random(95);
      drain();
    end

    repeat (600) @(posedge clk);
    if (mismatches == 0 && expected_views.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
